FILE: src/ffs_pkg.sv
package ffs_pkg;

  localparam int unsigned TYPE_LENGTH   = 4;
  localparam int unsigned BITMAP_LENGTH = 12;
  localparam int unsigned ELEMENT_COUNT = 12;
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam int unsigned CharW    = 8;
  localparam int unsigned SectionW = 2;
  localparam int unsigned ElemW    = 4;
  localparam int unsigned PosW     = 5;

  localparam logic [CharW-1:0] CHAR_ONE = 8'h31;

  typedef enum logic [SectionW-1:0] {
    SEC_TYPE    = 2'd0,
    SEC_BITMAP  = 2'd1,
    SEC_DATA    = 2'd2,
    SEC_SURPLUS = 2'd3
  } section_e;

  typedef struct packed {
    logic [SectionW-1:0] section;
    logic [ElemW-1:0]    element_number;
    logic [CharW-1:0]    char_out;
    logic [PosW-1:0]     position;
    logic                last_of_element;
  } result_t;

  // fixed length of data element idx + 1
  function automatic logic [PosW-1:0] elem_len(input logic [ElemW-1:0] idx);
    logic [PosW-1:0] len;
    unique case (idx)
      4'd0:    len = 5'd8;
      4'd1:    len = 5'd19;
      4'd2:    len = 5'd6;
      4'd3:    len = 5'd16;
      4'd4:    len = 5'd16;
      4'd5:    len = 5'd16;
      4'd6:    len = 5'd10;
      4'd7:    len = 5'd12;
      4'd8:    len = 5'd8;
      4'd9:    len = 5'd8;
      4'd10:   len = 5'd12;
      4'd11:   len = 5'd14;
      default: len = 5'd1;
    endcase
    return len;
  endfunction

endpackage

FILE: src/ffs_in_if.sv
interface ffs_in_if import ffs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_in;
  logic             message_start;

  modport source(output valid, output char_in, output message_start, input ready);
  modport sink(input valid, input char_in, input message_start, output ready);
endinterface

FILE: src/ffs_out_if.sv
interface ffs_out_if import ffs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SectionW-1:0] section;
  logic [ElemW-1:0]    element_number;
  logic [CharW-1:0]    char_out;
  logic [PosW-1:0]     position;
  logic                last_of_element;

  modport source(output valid, output section, output element_number, output char_out,
                 output position, output last_of_element, input ready);
  modport sink(input valid, input section, input element_number, input char_out,
               input position, input last_of_element, output ready);
endinterface

FILE: src/ffs_front.sv
module ffs_front import ffs_pkg::*; #(
  parameter int unsigned TypeLength = TYPE_LENGTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ffs_in_if.sink        in_i,
  output logic          push_valid_o,
  input  logic          push_ready_i,
  output result_t       push_data_o
);

  typedef enum logic [3:0] {
    ST_TYPE    = 4'b0001,
    ST_BITMAP  = 4'b0010,
    ST_DATA    = 4'b0100,
    ST_SURPLUS = 4'b1000
  } state_e;

  state_e                   state_q, state_d;
  logic [PosW-1:0]          offset_q, offset_d;
  logic [BITMAP_LENGTH-1:0] bits_q, bits_d;
  logic [ElemW-1:0]         elem_q, elem_d;

  state_e                   eff_state;
  logic [PosW-1:0]          eff_off;
  logic [BITMAP_LENGTH-1:0] eff_bits;
  logic [ElemW-1:0]         eff_elem;
  logic [ElemW-1:0]         search_from;
  logic [BITMAP_LENGTH-1:0] avail;
  logic                     found;
  logic [ElemW-1:0]         found_idx;
  logic [PosW:0]            off_inc;
  logic                     accept;

  assign accept       = in_i.valid && push_ready_i;
  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;
  assign off_inc      = {1'b0, eff_off} + (PosW+1)'(1);

  always_comb begin
    eff_state = in_i.message_start ? ST_TYPE : state_q;
    eff_off   = in_i.message_start ? '0 : offset_q;
    eff_bits  = in_i.message_start ? '0 : bits_q;
    eff_elem  = in_i.message_start ? '0 : elem_q;
    if (eff_state == ST_DATA &&
        (eff_elem == '0 || eff_elem > ElemW'(ELEMENT_COUNT))) begin
      eff_state = ST_SURPLUS;
      eff_elem  = '0;
      eff_off   = '0;
    end

    bits_d = eff_bits;
    if (eff_state == ST_BITMAP && eff_off < PosW'(BITMAP_LENGTH) &&
        in_i.char_in == CHAR_ONE) begin
      bits_d[eff_off[ElemW-1:0]] = 1'b1;
    end

    // lowest present element at or above the search start
    search_from = (eff_state == ST_BITMAP) ? '0 : eff_elem;
    for (int i = 0; i < BITMAP_LENGTH; i++) begin
      avail[i] = bits_d[i] && (ElemW'(i) >= search_from);
    end
    found     = 1'b0;
    found_idx = '0;
    for (int i = BITMAP_LENGTH - 1; i >= 0; i--) begin
      if (avail[i]) begin
        found     = 1'b1;
        found_idx = ElemW'(i);
      end
    end

    state_d  = eff_state;
    offset_d = eff_off;
    elem_d   = eff_elem;

    push_data_o.section         = SEC_SURPLUS;
    push_data_o.element_number  = '0;
    push_data_o.char_out        = in_i.char_in;
    push_data_o.position        = '0;
    push_data_o.last_of_element = 1'b0;

    unique case (eff_state)
      ST_TYPE: begin
        push_data_o.section  = SEC_TYPE;
        push_data_o.position = eff_off;
        if (off_inc >= (PosW+1)'(TypeLength)) begin
          push_data_o.last_of_element = 1'b1;
          state_d  = ST_BITMAP;
          offset_d = '0;
        end else begin
          offset_d = off_inc[PosW-1:0];
        end
      end
      ST_BITMAP: begin
        push_data_o.section  = SEC_BITMAP;
        push_data_o.position = eff_off;
        if (off_inc >= (PosW+1)'(BITMAP_LENGTH)) begin
          push_data_o.last_of_element = 1'b1;
          offset_d = '0;
          state_d  = found ? ST_DATA : ST_SURPLUS;
          elem_d   = found ? found_idx + ElemW'(1) : '0;
        end else begin
          offset_d = off_inc[PosW-1:0];
        end
      end
      ST_DATA: begin
        push_data_o.section        = SEC_DATA;
        push_data_o.element_number = eff_elem;
        push_data_o.position       = eff_off;
        if (off_inc >= {1'b0, elem_len(eff_elem - ElemW'(1))}) begin
          push_data_o.last_of_element = 1'b1;
          offset_d = '0;
          state_d  = found ? ST_DATA : ST_SURPLUS;
          elem_d   = found ? found_idx + ElemW'(1) : '0;
        end else begin
          offset_d = off_inc[PosW-1:0];
        end
      end
      ST_SURPLUS: begin
        push_data_o.section = SEC_SURPLUS;
      end
      default: begin
        push_data_o.section = SEC_SURPLUS;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_SURPLUS;
      offset_q <= '0;
      bits_q   <= '0;
      elem_q   <= '0;
    end else if (accept) begin
      state_q  <= state_d;
      offset_q <= offset_d;
      bits_q   <= bits_d;
      elem_q   <= elem_d;
    end
  end

  a_start_is_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.message_start |->
      push_data_o.section == SEC_TYPE && push_data_o.position == '0)
    else $error("start beat not tagged as type position 0");

  a_surplus_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && push_data_o.section == SEC_SURPLUS |->
      !push_data_o.last_of_element && push_data_o.position == '0 &&
      push_data_o.element_number == '0)
    else $error("surplus beat carries element info");

  a_data_elem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && push_data_o.section == SEC_DATA |->
      push_data_o.element_number != '0 &&
      push_data_o.element_number <= ElemW'(ELEMENT_COUNT))
    else $error("data beat with element number out of range");

endmodule

FILE: src/ffs_queue.sv
module ffs_queue import ffs_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  result_t   push_data_i,
  ffs_out_if.source out_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  result_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;
  result_t         head;

  assign push_ready_o = count_q != CntW'(Depth);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = out_o.valid && out_o.ready;
  assign head         = mem_q[rd_ptr_q];

  assign out_o.valid           = count_q != '0;
  assign out_o.section         = head.section;
  assign out_o.element_number  = head.element_number;
  assign out_o.char_out        = head.char_out;
  assign out_o.position        = head.position;
  assign out_o.last_of_element = head.last_of_element;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count above depth");

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && count_q == '0 |=> out_o.valid && $past(push_data_i) == head)
    else $error("beat pushed into empty queue not presented");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == '0 || count_q == CntW'(Depth) |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree with count");

endmodule

FILE: src/iso8583_fixed_field_splitter_core.sv
// an accepted character beat is written into the result queue and is presented on the output from there
// throughput: one character per cycle while the result queue has room, set by the combinational parse step in the front
// a two-entry result queue lets the input keep flowing while the output is stalled, until the queue is full
// reset: asynchronous active low; surplus section, empty bitmap and empty queue
module iso8583_fixed_field_splitter_core import ffs_pkg::*; #(
  parameter int unsigned TypeLength = TYPE_LENGTH,
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ffs_in_if.sink    in_i,
  ffs_out_if.source out_o
);

  logic    push_valid;
  logic    push_ready;
  result_t push_data;

  ffs_front #(
    .TypeLength(TypeLength)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_data_o (push_data)
  );

  ffs_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .out_o       (out_o)
  );

endmodule
